// File: design/ssfm_pkg.sv
// Shared types and constants for the streaming first-match substring search.
// Used by every module of the block and by its port checker.
package ssfm_pkg;

  localparam int NEEDLE_MAX   = 32;
  localparam int OFFSET_BITS  = 32;
  localparam int LEN_W        = 6;
  localparam int NEEDLE_WORDS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int RESULT_OFF_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_LENGTH  = 3'd0,
    REG_NEEDLE_BYTES_A = 3'd1,
    REG_NEEDLE_BYTES_B = 3'd2,
    REG_NEEDLE_BYTES_C = 3'd3,
    REG_NEEDLE_BYTES_D = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic                    found;
    logic [RESULT_OFF_W-1:0] match_offset;
  } out_beat_t;

  // Per-beat control handed from the cell chain to the tracker.
  typedef struct packed {
    logic accept;
    logic final_byte;
    logic match;
  } scan_ctrl_t;

endpackage

// File: design/substring_search_first_match.sv
// Streaming first-match substring search over a chain of prefix cells.
// Throughput: one haystack byte per clock while no result beat waits, set by the combinational compare in each cell.
// The result beat is registered and appears in the cycle after the final byte is accepted.
// Input stalls while a result beat waits; a result taken in the same cycle frees the slot.
// Reset (rst_ni low, asynchronous) clears the needle, its length and all match state.
module substring_search_first_match #(
  parameter int NeedleMax  = ssfm_pkg::NEEDLE_MAX,
  parameter int OffsetBits = ssfm_pkg::OFFSET_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ssfm_pkg::in_beat_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ssfm_pkg::out_beat_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [ssfm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssfm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [ssfm_pkg::LEN_W-1:0]                                len_q;
  logic [ssfm_pkg::NEEDLE_WORDS-1:0][ssfm_pkg::CFG_DATA_W-1:0] needle_q;
  logic [ssfm_pkg::LEN_W-1:0]                                len_wr;
  logic [NeedleMax:0]                                        chain;
  logic [NeedleMax-1:0]                                      top_hits;
  logic                                                      accept;
  ssfm_pkg::scan_ctrl_t                                      ctrl;

  assign len_wr = (cfg_data_i[ssfm_pkg::LEN_W-1:0] > ssfm_pkg::LEN_W'(NeedleMax)) ?
                  ssfm_pkg::LEN_W'(NeedleMax) : cfg_data_i[ssfm_pkg::LEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      needle_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssfm_pkg::REG_NEEDLE_LENGTH:  len_q       <= len_wr;
        ssfm_pkg::REG_NEEDLE_BYTES_A: needle_q[0] <= cfg_data_i;
        ssfm_pkg::REG_NEEDLE_BYTES_B: needle_q[1] <= cfg_data_i;
        ssfm_pkg::REG_NEEDLE_BYTES_C: needle_q[2] <= cfg_data_i;
        ssfm_pkg::REG_NEEDLE_BYTES_D: needle_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // The empty prefix always matches, so the chain is fed a constant one.
  assign chain[0] = 1'b1;

  for (genvar k = 0; k < NeedleMax; k++) begin : g_cell
    ssfm_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .accept_i      (accept),
      .clear_i       (in_data_i.final_byte),
      .text_byte_i   (in_data_i.text_byte),
      .needle_byte_i (needle_q[k/8][(k%8)*8 +: 8]),
      .needle_len_i  (len_q),
      .prev_hit_i    (chain[k]),
      .hit_o         (chain[k+1]),
      .top_hit_o     (top_hits[k])
    );
  end

  assign ctrl.accept     = accept;
  assign ctrl.final_byte = in_data_i.final_byte;
  assign ctrl.match      = (len_q == '0) || (|top_hits);

  ssfm_tracker #(
    .OffsetBits (OffsetBits)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .needle_len_i (len_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

endmodule

// File: design/ssfm_cell.sv
// One cell of the prefix chain: holds the partial-match bit for one needle prefix.
// Depends on ssfm_pkg for the needle length width.
module ssfm_cell #(
  parameter int CellIdx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       clear_i,
  input  logic [7:0]                 text_byte_i,
  input  logic [7:0]                 needle_byte_i,
  input  logic [ssfm_pkg::LEN_W-1:0] needle_len_i,
  input  logic                       prev_hit_i,
  output logic                       hit_o,
  output logic                       top_hit_o
);

  logic hit_q, hit_d;
  logic hit_new;

  // The prefix of length CellIdx+1 matches if the shorter prefix matched one
  // byte ago and this byte equals needle byte CellIdx.
  assign hit_new   = prev_hit_i && (text_byte_i == needle_byte_i);
  assign top_hit_o = hit_new && (needle_len_i == ssfm_pkg::LEN_W'(CellIdx + 1));
  assign hit_o     = hit_q;

  always_comb begin
    hit_d = hit_q;
    if (accept_i) begin
      hit_d = clear_i ? 1'b0 : hit_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

endmodule

// File: design/ssfm_tracker.sv
// Byte counter, first-hit capture and result register of the substring search.
// Depends on ssfm_pkg for the control struct and the result beat type.
module ssfm_tracker #(
  parameter int OffsetBits = ssfm_pkg::OFFSET_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssfm_pkg::scan_ctrl_t       ctrl_i,
  input  logic [ssfm_pkg::LEN_W-1:0] needle_len_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output ssfm_pkg::out_beat_t        out_data_o
);

  localparam int ExtW = (OffsetBits > ssfm_pkg::RESULT_OFF_W) ?
                        OffsetBits : ssfm_pkg::RESULT_OFF_W;

  logic [OffsetBits-1:0] bytes_q, bytes_d;
  logic [OffsetBits-1:0] first_q, first_d;
  logic                  seen_q, seen_d;
  logic                  out_valid_q, out_valid_d;
  ssfm_pkg::out_beat_t   out_data_q, out_data_d;
  logic [OffsetBits-1:0] cand_offset;
  logic [OffsetBits-1:0] hit_offset;
  logic [ExtW-1:0]       first_ext;

  assign cand_offset = (needle_len_i == '0) ? '0 :
                       (bytes_q + OffsetBits'(1) - OffsetBits'(needle_len_i));
  // Offset of the first hit including the current beat, before the stream is cleared.
  assign hit_offset  = (ctrl_i.match && !seen_q) ? cand_offset : first_q;
  assign first_ext   = ExtW'(hit_offset);

  always_comb begin
    bytes_d     = bytes_q;
    first_d     = first_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_i.accept) begin
      if (ctrl_i.match && !seen_q) begin
        seen_d  = 1'b1;
        first_d = cand_offset;
      end
      if (bytes_q != '1) begin
        bytes_d = bytes_q + OffsetBits'(1);
      end
      if (ctrl_i.final_byte) begin
        out_valid_d             = 1'b1;
        out_data_d.found        = seen_d;
        out_data_d.match_offset = seen_d ? first_ext[ssfm_pkg::RESULT_OFF_W-1:0] : '0;
        // The stream is over: start the next one from a clean state.
        bytes_d = '0;
        first_d = '0;
        seen_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q     <= '0;
      first_q     <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bytes_q     <= bytes_d;
      first_q     <= first_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/ssfm_checker.sv
// Port-level checks for the substring search block, attached by bind.
// Depends on ssfm_pkg for the beat types.
module ssfm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ssfm_pkg::in_beat_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ssfm_pkg::out_beat_t out_data_o
);

  // A waiting result beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // A result that reports no match carries a zero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.match_offset == '0)
    else $error("not-found result with nonzero offset");

  // A new result only follows an accepted final byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_data_i.final_byte))
    else $error("result without a final byte");

  // A byte that is not the last one never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.final_byte && !out_valid_o |=> !out_valid_o)
    else $error("result from a non-final byte");

endmodule

bind substring_search_first_match ssfm_checker u_ssfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: bench/substring_search_first_match_tb.sv
// Testbench for substring_search_first_match: streams haystacks through the block and
// compares each first-match result against a bit-level model of the prefix cell chain.
// Depends on ssfm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module substring_search_first_match_tb;

  localparam int ResultSettle = 4;     // cycles to wait after the owed results have come back
  localparam int DrainLimit   = 2000;  // cycles to wait for outstanding results
  localparam int TargetBytes  = 1700;

  // Tracks the needle configuration and per-stream match state, and holds the
  // results that the block still owes.
  class first_match_tracker;
    logic [ssfm_pkg::LEN_W-1:0]       needle_len;
    logic [ssfm_pkg::CFG_DATA_W-1:0]  needle_words [ssfm_pkg::NEEDLE_WORDS];
    logic [ssfm_pkg::NEEDLE_MAX-1:0]  prefix_hits;
    logic [ssfm_pkg::OFFSET_BITS-1:0] byte_pos;
    logic                             hit_seen;
    logic [ssfm_pkg::OFFSET_BITS-1:0] hit_offset;
    ssfm_pkg::out_beat_t              expected_results [$];
    int                               mismatches;
    int                               results_checked;

    function new();
      needle_len = '0;
      foreach (needle_words[i]) needle_words[i] = '0;
      mismatches = 0;
      results_checked = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      prefix_hits = '0;
      byte_pos    = '0;
      hit_seen    = 1'b0;
      hit_offset  = '0;
    endfunction

    function logic [7:0] needle_byte(int k);
      return needle_words[k / 8][8 * (k % 8) +: 8];
    endfunction

    function void write_reg(logic [ssfm_pkg::CFG_IDX_W-1:0] idx,
                            logic [ssfm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ssfm_pkg::REG_NEEDLE_LENGTH: begin
          needle_len = (data[ssfm_pkg::LEN_W-1:0] > ssfm_pkg::NEEDLE_MAX) ?
                       ssfm_pkg::LEN_W'(ssfm_pkg::NEEDLE_MAX) : data[ssfm_pkg::LEN_W-1:0];
        end
        ssfm_pkg::REG_NEEDLE_BYTES_A, ssfm_pkg::REG_NEEDLE_BYTES_B,
        ssfm_pkg::REG_NEEDLE_BYTES_C, ssfm_pkg::REG_NEEDLE_BYTES_D: begin
          needle_words[int'(idx) - int'(ssfm_pkg::REG_NEEDLE_BYTES_A)] = data;
        end
        default: ;
      endcase
    endfunction

    function void scan_byte(ssfm_pkg::in_beat_t beat);
      logic [ssfm_pkg::NEEDLE_MAX-1:0] byte_eq;
      ssfm_pkg::out_beat_t             result;
      for (int k = 0; k < ssfm_pkg::NEEDLE_MAX; k++)
        byte_eq[k] = (needle_byte(k) == beat.text_byte);
      prefix_hits = {prefix_hits[ssfm_pkg::NEEDLE_MAX-2:0], 1'b1} & byte_eq;
      if (!hit_seen) begin
        if (needle_len == 0) begin
          hit_seen   = 1'b1;
          hit_offset = '0;
        end else if (prefix_hits[needle_len - 1]) begin
          hit_seen   = 1'b1;
          hit_offset = byte_pos + 1 - ssfm_pkg::OFFSET_BITS'(needle_len);
        end
      end
      // The position counter sticks at its maximum.
      if (byte_pos != '1) byte_pos++;
      if (beat.final_byte) begin
        result.found        = hit_seen;
        result.match_offset = hit_seen ? hit_offset[ssfm_pkg::RESULT_OFF_W-1:0] : '0;
        expected_results.push_back(result);
        clear_stream();
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(ssfm_pkg::out_beat_t got);
      ssfm_pkg::out_beat_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat found=%0b offset=%0d",
                                  got.found, got.match_offset));
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      if (got.found !== want.found)
        report_mismatch($sformatf("found is %0b, expected %0b", got.found, want.found));
      if (got.match_offset !== want.match_offset)
        report_mismatch($sformatf("match_offset is %0d, expected %0d",
                                  got.match_offset, want.match_offset));
    endtask
  endclass

  logic                            clk;
  logic                            rst_ni    = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  ssfm_pkg::in_beat_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  ssfm_pkg::out_beat_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [ssfm_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [ssfm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  bit                              steady_flow = 1'b0;
  int                              bytes_sent = 0;
  int                              streams_sent = 0;
  int                              needle_settings = 0;
  logic [7:0]                      haystack [$];
  first_match_tracker              tracker = new();

  substring_search_first_match DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) tracker.check_result(out_data);
  end

  task automatic cfg_write(logic [ssfm_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssfm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    tracker.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] value, logic last);
    if (!steady_flow && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_byte: value, final_byte: last};
    do @(posedge clk); while (!in_ready);
    tracker.scan_byte(in_data);
    bytes_sent++;
  endtask

  task automatic send_haystack();
    foreach (haystack[i]) send_byte(haystack[i], i == haystack.size() - 1);
    streams_sent++;
  endtask

  // Wait until every owed result has come back or DrainLimit runs out, then let the pipeline settle.
  task automatic drain();
    int waited = 0;
    in_valid <= 1'b0;
    while (tracker.expected_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (ResultSettle) @(posedge clk);
  endtask

  task automatic random_needle();
    int                              pick = $urandom_range(99);
    int                              len;
    bit                              narrow = $urandom_range(1);
    logic [7:0]                      sym_a = 8'($urandom);
    logic [7:0]                      sym_b = 8'($urandom);
    logic [ssfm_pkg::CFG_DATA_W-1:0] words [ssfm_pkg::NEEDLE_WORDS];
    logic [ssfm_pkg::CFG_DATA_W-1:0] len_word;
    if (pick < 6) len = 0;
    else if (pick < 16) len = ssfm_pkg::NEEDLE_MAX;
    else if (pick < 70) len = $urandom_range(1, 6);
    else len = $urandom_range(7, ssfm_pkg::NEEDLE_MAX - 1);
    foreach (words[w]) words[w] = {$urandom, $urandom};
    // A two-symbol alphabet gives self-overlapping needles and many partial hits.
    if (narrow) begin
      for (int k = 0; k < len; k++)
        words[k / 8][8 * (k % 8) +: 8] = $urandom_range(1) ? sym_a : sym_b;
    end
    len_word = ssfm_pkg::CFG_DATA_W'(len);
    if ($urandom_range(99) < 20) begin
      len_word = {$urandom, $urandom};
      len_word[ssfm_pkg::LEN_W-1:0] = ssfm_pkg::LEN_W'(len);
    end
    if (len == ssfm_pkg::NEEDLE_MAX && $urandom_range(1))
      len_word = ssfm_pkg::CFG_DATA_W'($urandom_range(ssfm_pkg::NEEDLE_MAX + 1,
                                                      (1 << ssfm_pkg::LEN_W) - 1));
    cfg_write(ssfm_pkg::REG_NEEDLE_LENGTH, len_word);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_A, words[0]);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_B, words[1]);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_C, words[2]);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_D, words[3]);
    if ($urandom_range(99) < 15)
      cfg_write(ssfm_pkg::CFG_IDX_W'($urandom_range(int'(ssfm_pkg::REG_NEEDLE_BYTES_D) + 1,
                                                    (1 << ssfm_pkg::CFG_IDX_W) - 1)),
                {$urandom, $urandom});
    needle_settings++;
  endtask

  task automatic random_stream();
    int len   = int'(tracker.needle_len);
    bit plant = $urandom_range(99) < 60;
    int count;
    int at;
    int part;
    count = plant ? len + $urandom_range(0, 12) : $urandom_range(1, 20);
    if (count == 0) count = 1;
    haystack.delete();
    for (int i = 0; i < count; i++) begin
      if (len > 0 && $urandom_range(99) < 60)
        haystack.push_back(tracker.needle_byte($urandom_range(0, len - 1)));
      else
        haystack.push_back(8'($urandom));
    end
    if (plant && len > 0) begin
      at = $urandom_range(0, count - len);
      for (int k = 0; k < len; k++) haystack[at + k] = tracker.needle_byte(k);
    end else if (len > 1 && $urandom_range(1)) begin
      // A near miss: only a proper prefix of the needle.
      part = $urandom_range(1, len - 1);
      if (part <= count) begin
        at = $urandom_range(0, count - part);
        for (int k = 0; k < part; k++) haystack[at + k] = tracker.needle_byte(k);
      end
    end
    send_haystack();
  endtask

  initial begin
    int phase = 0;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Empty needle straight out of reset matches at offset zero.
    haystack = '{8'h00};
    send_haystack();
    haystack = '{8'hFF, 8'h00};
    send_haystack();
    drain();

    // An oversized length saturates; a haystack shorter than the needle cannot match.
    cfg_write(ssfm_pkg::REG_NEEDLE_LENGTH, '1);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_A, '1);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_B, '1);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_C, '1);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_D, '1);
    haystack = '{8'hFF, 8'hFF, 8'hFF};
    send_haystack();
    drain();

    // Length bits above the register width are dropped; unmapped indexes are ignored.
    cfg_write(ssfm_pkg::REG_NEEDLE_LENGTH, 64'hFFFF_FFFF_FFFF_FFC2);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_A, 64'hFF00);
    for (int i = int'(ssfm_pkg::REG_NEEDLE_BYTES_D) + 1; i < (1 << ssfm_pkg::CFG_IDX_W); i++)
      cfg_write(ssfm_pkg::CFG_IDX_W'(i), '0);
    haystack = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_haystack();
    drain();

    // A needle change in the middle of a stream keeps the partial match already held.
    send_byte(8'h00, 1'b0);
    drain();
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_A, 64'h1100);
    send_byte(8'h11, 1'b1);
    streams_sent++;
    drain();

    // Single-byte needle at the start, at the end, and absent.
    cfg_write(ssfm_pkg::REG_NEEDLE_LENGTH, 64'd1);
    cfg_write(ssfm_pkg::REG_NEEDLE_BYTES_A, 64'hAB);
    haystack = '{8'hAB};
    send_haystack();
    haystack = '{8'h01, 8'h02, 8'hAB};
    send_haystack();
    haystack = '{8'h00, 8'hFF};
    send_haystack();
    needle_settings += 4;

    while (bytes_sent < TargetBytes) begin
      drain();
      random_needle();
      steady_flow = (phase >= 5 && phase <= 7);
      repeat ($urandom_range(4, 10)) random_stream();
      phase++;
    end
    steady_flow = 1'b0;
    drain();

    while (tracker.expected_results.size() != 0) begin
      void'(tracker.expected_results.pop_front());
      tracker.report_mismatch("stream ended without a result beat");
    end

    $display("Scanned %0d haystack bytes in %0d streams over %0d needle settings;",
             bytes_sent, streams_sent, needle_settings);
    $display("compared %0d first-match results.", tracker.results_checked);
    if (tracker.mismatches == 0) begin
      $display("PASS substring_search_first_match");
    end else begin
      $display("FAIL substring_search_first_match");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out.");
    $display("FAIL substring_search_first_match");
    $finish;
  end

endmodule

// File: sim.f
design/ssfm_pkg.sv
design/ssfm_cell.sv
design/ssfm_tracker.sv
design/substring_search_first_match.sv
design/ssfm_checker.sv
bench/substring_search_first_match_tb.sv
